FILE: hw/rtl/mis_pkg.sv
// Package for the merge insertion sorter: sizes, payload types and
// controller-to-datapath command/status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mis_pkg;
   localparam int MaxItems = 64;
   localparam int IdxW = $clog2(MaxItems);
   localparam int CntW = $clog2(MaxItems + 1);

   typedef logic [IdxW-1:0] idx_type;
   typedef logic [CntW-1:0] cnt_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last_item;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               last_result;
   } rsp_type;

   // Commands from the controller into the datapath.
   typedef struct packed {
      logic    store;      // write incoming value at count, bump count
      logic    rd_issue;   // read memory at rd_addr
      idx_type rd_addr;
      logic    cand_load;  // latch read data as insertion candidate
      logic    cmp_load;   // latch read data as comparison element
      logic    wr_shift;   // write comparison element one slot up
      idx_type wr_addr;
      logic    wr_cand;    // write candidate at wr_addr
      logic    out_load;   // latch read data into output register
      logic    clear_cnt;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cnt_type count;
      logic    cmp_gt;     // comparison element > candidate
   } sts_type;
endpackage
`default_nettype wire

FILE: hw/rtl/mis_if.sv
// Valid/ready channel interface carrying one payload type.
// Depends on mis_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none
interface mis_req_if;
   logic             valid;
   logic             ready;
   mis_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mis_rsp_if;
   logic             valid;
   logic             ready;
   mis_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/mis_datapath.sv
// Datapath of the sorter: value memory, item count, candidate and compare
// registers, signed compare. Depends on mis_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mis_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mis_pkg::cmd_type    cmd,
   input  wire logic signed [31:0]  in_value,
   output mis_pkg::sts_type         sts,
   output logic signed [31:0]       out_value
);
   logic signed [31:0] mem [mis_pkg::MaxItems];
   logic signed [31:0] rd_data_ff;
   logic signed [31:0] cand_ff;
   logic signed [31:0] cmpv_ff;
   logic signed [31:0] out_ff;
   mis_pkg::cnt_type   count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (cmd.clear_cnt) begin
         count_in = '0;
      end else if (cmd.store && count_ff < mis_pkg::cnt_type'(mis_pkg::MaxItems)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Single write port, single registered read port.
   always_ff @(posedge clock) begin
      if (cmd.store && count_ff < mis_pkg::cnt_type'(mis_pkg::MaxItems)) begin
         mem[count_ff[mis_pkg::IdxW-1:0]] <= in_value;
      end else if (cmd.wr_shift) begin
         mem[cmd.wr_addr] <= cmpv_ff;
      end else if (cmd.wr_cand) begin
         mem[cmd.wr_addr] <= cand_ff;
      end
      if (cmd.rd_issue) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cand_load) cand_ff <= rd_data_ff;
      if (cmd.cmp_load)  cmpv_ff <= rd_data_ff;
      if (cmd.out_load)  out_ff  <= rd_data_ff;
   end

   assign sts.count  = count_ff;
   assign sts.cmp_gt = cmpv_ff > cand_ff;
   assign out_value  = out_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/mis_controller.sv
// Controller of the sorter: load, insertion sort sequencer and output drain.
// Depends on mis_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mis_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_last,
   output logic                  req_ready,
   output logic                  rsp_valid,
   output logic                  rsp_last,
   input  wire logic             rsp_ready,
   input  wire mis_pkg::sts_type sts,
   output mis_pkg::cmd_type      cmd
);
   typedef enum logic [8:0] {
      ST_LOAD  = 9'b000000001,
      ST_OUTER = 9'b000000010,
      ST_CWAIT = 9'b000000100,
      ST_CLAT  = 9'b000001000,
      ST_RWAIT = 9'b000010000,
      ST_RLAT  = 9'b000100000,
      ST_DECIDE= 9'b001000000,
      ST_ORD   = 9'b010000000,
      ST_OSHOW = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   mis_pkg::cnt_type i_ff, i_in;   // outer index / output index
   mis_pkg::cnt_type j_ff, j_in;   // insertion hole
   logic             val_ff, val_in;
   logic             last_ff, last_in;

   always_comb begin
      state_in  = state_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      val_in    = val_ff;
      last_in   = last_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store = 1'b1;
               if (req_last) begin
                  i_in     = mis_pkg::cnt_type'(1);
                  state_in = ST_OUTER;
               end
            end
         end
         ST_OUTER: begin
            if (i_ff >= sts.count) begin
               i_in     = '0;
               state_in = ST_ORD;
            end else begin
               cmd.rd_issue = 1'b1;
               cmd.rd_addr  = i_ff[mis_pkg::IdxW-1:0];
               j_in         = i_ff;
               state_in     = ST_CWAIT;
            end
         end
         ST_CWAIT: begin
            cmd.cand_load = 1'b1;
            state_in      = ST_CLAT;
         end
         ST_CLAT: begin
            if (j_ff == '0) begin
               cmd.wr_cand = 1'b1;
               cmd.wr_addr = '0;
               i_in        = i_ff + 1'b1;
               state_in    = ST_OUTER;
            end else begin
               cmd.rd_issue = 1'b1;
               cmd.rd_addr  = mis_pkg::idx_type'(j_ff - 1'b1);
               state_in     = ST_RWAIT;
            end
         end
         ST_RWAIT: begin
            cmd.cmp_load = 1'b1;
            state_in     = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.cmp_gt) begin
               // shift element up one slot, move hole down
               cmd.wr_shift = 1'b1;
               cmd.wr_addr  = j_ff[mis_pkg::IdxW-1:0];
               j_in         = j_ff - 1'b1;
               state_in     = ST_CLAT;
            end else begin
               cmd.wr_cand = 1'b1;
               cmd.wr_addr = j_ff[mis_pkg::IdxW-1:0];
               i_in        = i_ff + 1'b1;
               state_in    = ST_OUTER;
            end
         end
         ST_RLAT: begin
            cmd.out_load = 1'b1;
            val_in       = 1'b1;
            last_in      = (i_ff + 1'b1 == sts.count);
            i_in         = i_ff + 1'b1;
            state_in     = ST_OSHOW;
         end
         ST_ORD: begin
            if (i_ff >= sts.count) begin
               cmd.clear_cnt = 1'b1;
               state_in      = ST_LOAD;
            end else begin
               cmd.rd_issue = 1'b1;
               cmd.rd_addr  = i_ff[mis_pkg::IdxW-1:0];
               state_in     = ST_RLAT;
            end
         end
         ST_OSHOW: begin
            if (rsp_ready) begin
               val_in   = 1'b0;
               state_in = ST_ORD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         i_ff     <= '0;
         j_ff     <= '0;
         val_ff   <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         val_ff   <= val_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid = val_ff;
   assign rsp_last  = last_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/merge_insertion_sorter_unit.sv
// Usage: req carries {value, last_item}; one beat per value is stored in a
// 64-entry memory. A beat with last_item closes the batch (beats past 64 are
// dropped but last_item still closes it). The block then insertion-sorts the
// batch in place over its memory (one write, one read port) and drains it
// on rsp, ascending, last_result set on the largest value.
// Sorting runs one outer step per stored value after the first: the value is
// read as candidate, each element below it is read and compared, and each
// larger one is shifted up one slot until the hole is found, where the
// candidate is written. Each result beat is then read and held until taken.
// Throughput: one req beat per cycle while loading. The memory's one read
// port and the compare loop set the sorting time.
// req_ready is low from the closing beat until the block returns to loading
// after the last result is taken. A stalled rsp holds its beat. Synchronous
// reset empties the batch; the memory content is not cleared.
// Depends on mis_pkg, mis_if, mis_datapath and mis_controller.
`timescale 1ns / 1ps
`default_nettype none
module merge_insertion_sorter_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   mis_req_if.sink    req,
   mis_rsp_if.source  rsp
);
   mis_pkg::cmd_type   cmd;
   mis_pkg::sts_type   sts;
   logic signed [31:0] out_value;
   logic               rsp_last;

   mis_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.data.last_item),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_last  (rsp_last),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mis_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .in_value  (req.data.value),
      .sts       (sts),
      .out_value (out_value)
   );

   assign rsp.data.sorted_value = out_value;
   assign rsp.data.last_result  = rsp_last;
endmodule
`default_nettype wire

FILE: hw/rtl/mis_checker.sv
// Port-level checker for the sorter, bound to the top level.
// Depends on mis_if through the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module mis_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_last,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic signed [31:0] rsp_value,
   input wire logic        rsp_last
);
   logic               have_prev_ff;
   logic signed [31:0] prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         have_prev_ff <= !rsp_last;
         prev_ff      <= rsp_value;
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_last))
      else $error("rsp beat changed under stall");
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && have_prev_ff |-> rsp_value >= prev_ff)
      else $error("results not ascending");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken during drain");
   a_close: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("input still open after closing beat");
endmodule

bind merge_insertion_sorter_unit mis_checker u_mis_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .req_last  (req.data.last_item),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_value (rsp.data.sorted_value),
   .rsp_last  (rsp.data.last_result)
);
`default_nettype wire

FILE: dv/tb_merge_insertion_sorter_unit.sv
// Testbench for merge_insertion_sorter_unit: drives batches of signed values,
// predicts the ascending drain and checks every result beat in order.
// Depends on mis_pkg, mis_if and the sorter RTL.
`timescale 1ns / 1ps
module tb_merge_insertion_sorter_unit;

   localparam int PeriodHalf = 5;
   localparam longint CycleLimit = 3000000;

   typedef struct {
      logic signed [31:0] value;
      logic               last_item;
      logic               has_rsp;     // typed-in result follows
      logic signed [31:0] rsp_value;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   mis_req_if req ();
   mis_rsp_if rsp ();

   merge_insertion_sorter_unit dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #PeriodHalf clock = 1'b1;
      #PeriodHalf clock = 1'b0;
   end

   mis_pkg::rsp_type sorted_queue[$];
   logic signed [31:0] batch_values[$];
   logic signed [31:0] typed_queue[$];
   int  fail_count = 0;
   longint cycle_count = 0;
   bit  no_idle = 1'b0;
   bit  hold_start = 1'b0;
   bit  hold_used = 1'b0;
   int  hold_off = 0;
   bit  stim_done = 1'b0;

   // Sort the held batch and append its drain to the expected queue.
   task automatic predict_drain();
      logic signed [31:0] vals[$];
      logic signed [31:0] tmp;
      mis_pkg::rsp_type r;
      int j;
      vals = batch_values;
      for (int i = 1; i < vals.size(); i++) begin
         tmp = vals[i];
         j = i;
         while (j > 0 && vals[j-1] > tmp) begin
            vals[j] = vals[j-1];
            j--;
         end
         vals[j] = tmp;
      end
      foreach (vals[k]) begin
         r.sorted_value = vals[k];
         r.last_result = (k == vals.size() - 1);
         sorted_queue.insert(sorted_queue.size(), r);
      end
      batch_values.delete();
   endtask

   task automatic send_beat(input logic signed [31:0] v, input logic l);
      if (!no_idle && $urandom_range(99) < 31) begin
         req.valid <= 1'b0;
         do @(posedge clock); while (!no_idle && $urandom_range(99) < 31);
      end
      req.valid <= 1'b1;
      req.data.value <= v;
      req.data.last_item <= l;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (batch_values.size() < mis_pkg::MaxItems)
         batch_values.insert(batch_values.size(), v);
      if (l) predict_drain();
   endtask

   // Drop valid and wait for every expected beat.
   task automatic wait_drained();
      req.valid <= 1'b0;
      while (sorted_queue.size() != 0) @(posedge clock);
   endtask

   stim_row_type rows[$];

   task automatic add_row(input logic signed [31:0] v, input logic l, input logic h,
                          input logic signed [31:0] r);
      stim_row_type row;
      row.value = v;
      row.last_item = l;
      row.has_rsp = h;
      row.rsp_value = r;
      rows.insert(rows.size(), row);
   endtask

   initial begin
      int n;
      int mode;
      req.valid = 1'b0;
      req.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Single values at the extremes, with zero, then small mixed batches.
      add_row(32'sh80000000, 1'b1, 1'b1, 32'sh80000000);
      add_row(32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff);
      add_row(32'sd0, 1'b1, 1'b1, 32'sd0);
      add_row(-32'sd1, 1'b1, 1'b1, -32'sd1);
      add_row(32'sh7fffffff, 1'b0, 1'b0, 0);
      add_row(32'sh80000000, 1'b0, 1'b0, 0);
      add_row(32'sd0, 1'b1, 1'b0, 0);
      add_row(32'sd5, 1'b0, 1'b0, 0);
      add_row(32'sd5, 1'b0, 1'b0, 0);
      add_row(-32'sd3, 1'b0, 1'b0, 0);
      add_row(32'sd0, 1'b0, 1'b0, 0);
      add_row(32'sd5, 1'b1, 1'b0, 0);
      add_row(32'sd9, 1'b0, 1'b0, 0);
      add_row(32'sd0, 1'b1, 1'b0, 0);
      foreach (rows[i]) begin
         if (rows[i].has_rsp) typed_queue.insert(typed_queue.size(), rows[i].rsp_value);
         send_beat(rows[i].value, rows[i].last_item);
      end
      wait_drained();

      // Overfill: 70 beats, descending, so the sort does its longest work.
      for (int i = 0; i < 70; i++)
         send_beat($signed(32'h40000000 - i * 32'h01000000), i == 69);

      // Receiver hold-off while the sender keeps offering.
      hold_start = 1'b1;
      for (int i = 0; i < 10; i++) send_beat($urandom, i == 9);
      send_beat($urandom, 1'b0);
      send_beat($urandom, 1'b1);
      wait_drained();

      // Random batches, mostly small; a quiet stretch without idling.
      n = 0;
      while (n < 55) begin
         int sz;
         mode = $urandom_range(9);
         sz = (mode == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         no_idle = (n > 15 && n < 35);
         for (int i = 0; i < sz; i++) begin
            logic signed [31:0] v;
            case ($urandom_range(3))
               0: v = $signed($urandom_range(7)) - 4;
               1: v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
               default: v = $urandom;
            endcase
            send_beat(v, i == sz - 1);
         end
         n += sz;
      end
      no_idle = 1'b0;
      wait_drained();
      repeat (200) @(posedge clock);
      stim_done = 1'b1;
   end

   // Receiver: random stalls and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_start && !hold_used) begin
         hold_used <= 1'b1;
         hold_off <= 400;
         rsp.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= no_idle || ($urandom_range(99) >= 31);
      end
   end

   // Check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      mis_pkg::rsp_type e;
      logic signed [31:0] t;
      if (!reset && rsp.valid && rsp.ready) begin
         if (sorted_queue.size() == 0) begin
            $display("%0t unexpected result: actual %0d/%0b", $time,
                     rsp.data.sorted_value, rsp.data.last_result);
            fail_count++;
         end else begin
            e = sorted_queue.pop_front();
            if (e.last_result && typed_queue.size() != 0 &&
                sorted_queue.size() == 0) begin
               t = typed_queue.pop_front();
               if (t !== rsp.data.sorted_value) begin
                  $display("%0t table row: expected %0d actual %0d", $time, t,
                           rsp.data.sorted_value);
                  fail_count++;
               end
            end
            if (rsp.data.sorted_value !== e.sorted_value) begin
               $display("%0t sorted_value: expected %0d actual %0d", $time,
                        e.sorted_value, rsp.data.sorted_value);
               fail_count++;
            end
            if (rsp.data.last_result !== e.last_result) begin
               $display("%0t last_result: expected %0b actual %0b", $time,
                        e.last_result, rsp.data.last_result);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stim_done) begin
         if (fail_count == 0 && sorted_queue.size() == 0)
            $display("merge_insertion_sorter_unit test passed");
         else
            $display("merge_insertion_sorter_unit test failed");
         $finish;
      end else if (cycle_count > CycleLimit) begin
         $display("merge_insertion_sorter_unit test failed");
         $finish;
      end
   end
endmodule
